### src/lmt_pkg.sv
// ----------------------------------------------------------------------------
// lmt_pkg
// Shared types, character codes and classifiers for the math tokenizer.
// ----------------------------------------------------------------------------
package lmt_pkg;

  typedef enum logic [3:0] {
    KIND_IDENT    = 4'd0,
    KIND_NUMBER   = 4'd1,
    KIND_COMMAND  = 4'd2,
    KIND_LBRACE   = 4'd3,
    KIND_RBRACE   = 4'd4,
    KIND_LBRACKET = 4'd5,
    KIND_RBRACKET = 4'd6,
    KIND_LPAREN   = 4'd7,
    KIND_RPAREN   = 4'd8,
    KIND_SUP      = 4'd9,
    KIND_SUB      = 4'd10,
    KIND_OTHER    = 4'd11,
    KIND_END      = 4'd12
  } tok_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_CMD  = 2'd1,
    MODE_NUM  = 2'd2
  } scan_mode_t;

  typedef struct packed {
    logic             push;
    logic [1:0]       n_tok;
    tok_kind_t [2:0]  kind;
  } lex_ctl_t;

  localparam int BUNDLE_DEPTH = 4;
  localparam int BPTR_W       = 2;
  localparam int BCNT_W       = 3;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_CARET     = 8'h5E;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic tok_kind_t single_kind(input logic [7:0] c);
    tok_kind_t k;
    case (c)
      CH_LBRACE:     k = KIND_LBRACE;
      CH_RBRACE:     k = KIND_RBRACE;
      CH_LBRACKET:   k = KIND_LBRACKET;
      CH_RBRACKET:   k = KIND_RBRACKET;
      CH_LPAREN:     k = KIND_LPAREN;
      CH_RPAREN:     k = KIND_RPAREN;
      CH_CARET:      k = KIND_SUP;
      CH_UNDERSCORE: k = KIND_SUB;
      default:       k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

### src/lmt_lexer.sv
// ----------------------------------------------------------------------------
// lmt_lexer
// Input register, scan state and the per-byte token group builder.
// ----------------------------------------------------------------------------
module lmt_lexer import lmt_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        acc,
  input  logic [7:0]                  ch,
  input  logic                        eoi,
  output logic                        busy,
  output lex_ctl_t                    ctl,
  output logic [2:0][OFFSET_BITS-1:0] tok_start,
  output logic [2:0][OFFSET_BITS-1:0] tok_length
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
  localparam logic [OFFSET_BITS-1:0] OFF_ONE = OFFSET_BITS'(1);

  logic                   in_valid;
  logic [7:0]             in_ch;
  logic                   in_eoi;
  scan_mode_t             mode, mode_next;
  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic [OFFSET_BITS-1:0] pending_start, pending_start_next;
  logic [OFFSET_BITS-1:0] pending_length, pending_length_next;

  logic [OFFSET_BITS-1:0] pos_inc;
  logic [OFFSET_BITS-1:0] len_inc;
  logic                   consumed;
  scan_mode_t             mid_mode;
  logic [3:0]             cv;
  tok_kind_t              ck [4];
  logic [OFFSET_BITS-1:0] cs [4];
  logic [OFFSET_BITS-1:0] cl [4];
  logic [2:0]             idx;

  assign pos_inc = (byte_position == OFF_MAX) ? byte_position : byte_position + OFF_ONE;
  assign len_inc = (pending_length == OFF_MAX) ? pending_length : pending_length + OFF_ONE;

  always_comb begin
    consumed            = 1'b0;
    mid_mode            = mode;
    pending_start_next  = pending_start;
    pending_length_next = pending_length;
    byte_position_next  = pos_inc;
    cv = '0;
    for (int i = 0; i < 4; i++) begin
      ck[i] = KIND_OTHER;
      cs[i] = '0;
      cl[i] = '0;
    end

    case (mode)
      MODE_CMD: begin
        if (is_letter(in_ch)) begin
          pending_length_next = len_inc;
          consumed = 1'b1;
        end else begin
          cv[0] = 1'b1;
          ck[0] = KIND_COMMAND;
          cs[0] = pending_start;
          cl[0] = pending_length;
          mid_mode = MODE_IDLE;
        end
      end
      MODE_NUM: begin
        if (is_digit(in_ch) || in_ch == CH_DOT) begin
          pending_length_next = len_inc;
          consumed = 1'b1;
        end else begin
          cv[0] = 1'b1;
          ck[0] = KIND_NUMBER;
          cs[0] = pending_start;
          cl[0] = pending_length;
          mid_mode = MODE_IDLE;
        end
      end
      default: begin
        mid_mode = MODE_IDLE;
      end
    endcase

    if (!consumed && !is_space(in_ch)) begin
      if (in_ch == CH_BACKSLASH) begin
        mid_mode = MODE_CMD;
        pending_start_next  = pos_inc;
        pending_length_next = '0;
      end else if (is_digit(in_ch)) begin
        mid_mode = MODE_NUM;
        pending_start_next  = byte_position;
        pending_length_next = OFF_ONE;
      end else begin
        cv[1] = 1'b1;
        ck[1] = is_letter(in_ch) ? KIND_IDENT : single_kind(in_ch);
        cs[1] = byte_position;
        cl[1] = OFF_ONE;
      end
    end

    mode_next = mid_mode;
    if (in_eoi) begin
      if (mid_mode == MODE_CMD || mid_mode == MODE_NUM) begin
        cv[2] = 1'b1;
        ck[2] = (mid_mode == MODE_CMD) ? KIND_COMMAND : KIND_NUMBER;
        cs[2] = pending_start_next;
        cl[2] = pending_length_next;
      end
      cv[3] = 1'b1;
      ck[3] = KIND_END;
      cs[3] = pos_inc;
      cl[3] = '0;
      mode_next           = MODE_IDLE;
      byte_position_next  = '0;
      pending_start_next  = '0;
      pending_length_next = '0;
    end
  end

  // pack the present tokens into the low slots of the group
  always_comb begin
    idx = '0;
    ctl.kind   = {3{KIND_OTHER}};
    tok_start  = '0;
    tok_length = '0;
    for (int i = 0; i < 4; i++) begin
      if (cv[i]) begin
        if (idx < 3'd3) begin
          ctl.kind[idx[1:0]]   = ck[i];
          tok_start[idx[1:0]]  = cs[i];
          tok_length[idx[1:0]] = cl[i];
        end
        idx = idx + 3'd1;
      end
    end
    ctl.n_tok = idx[1:0];
    ctl.push  = in_valid && (idx != 3'd0);
  end

  assign busy = in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      mode           <= MODE_IDLE;
      byte_position  <= '0;
      pending_start  <= '0;
      pending_length <= '0;
    end else begin
      in_valid <= acc;
      if (in_valid) begin
        mode           <= mode_next;
        byte_position  <= byte_position_next;
        pending_start  <= pending_start_next;
        pending_length <= pending_length_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      in_ch  <= ch;
      in_eoi <= eoi;
    end
  end

endmodule

### src/lmt_token_queue.sv
// ----------------------------------------------------------------------------
// lmt_token_queue
// Queue of token groups, drained one token per transfer.
// ----------------------------------------------------------------------------
module lmt_token_queue import lmt_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lex_ctl_t                    ctl,
  input  logic [2:0][OFFSET_BITS-1:0] tok_start,
  input  logic [2:0][OFFSET_BITS-1:0] tok_length,
  output logic [BCNT_W-1:0]           count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tok_kind_t                   out_kind,
  output logic [OFFSET_BITS-1:0]      out_start,
  output logic [OFFSET_BITS-1:0]      out_length,
  output logic                        out_last
);

  tok_kind_t [2:0]             q_kind   [BUNDLE_DEPTH];
  logic [1:0]                  q_n      [BUNDLE_DEPTH];
  logic [2:0][OFFSET_BITS-1:0] q_start  [BUNDLE_DEPTH];
  logic [2:0][OFFSET_BITS-1:0] q_length [BUNDLE_DEPTH];

  logic [BPTR_W-1:0] wr_ptr, rd_ptr;
  logic [1:0]        tok_idx;
  logic              pop;

  assign out_valid  = count != '0;
  assign out_kind   = q_kind[rd_ptr][tok_idx];
  assign out_start  = q_start[rd_ptr][tok_idx];
  assign out_length = q_length[rd_ptr][tok_idx];
  assign out_last   = tok_idx == (q_n[rd_ptr] - 2'd1);
  assign pop        = out_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
      tok_idx <= '0;
    end else begin
      if (ctl.push) begin
        wr_ptr <= wr_ptr + BPTR_W'(1);
      end
      if (out_valid && out_ready) begin
        tok_idx <= out_last ? 2'd0 : tok_idx + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + BPTR_W'(1);
      end
      count <= count + BCNT_W'(ctl.push) - BCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      q_kind[wr_ptr]   <= ctl.kind;
      q_n[wr_ptr]      <= ctl.n_tok;
      q_start[wr_ptr]  <= tok_start;
      q_length[wr_ptr] <= tok_length;
    end
  end

endmodule

### src/latex_math_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// latex_math_tokenizer_unit
// Streaming lexer for math markup: one byte in, zero to three tokens out.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while input ready is high. An accepted byte is held
// in the input register and lexed from there; its token group is written into
// the group queue, from which tokens leave one per cycle while the sink is
// ready. A byte may give up to three (flushed token, own token, end token),
// held as one group in a four-entry group queue. Input ready drops while that
// queue, with the byte in the lexing register, has no free group slot, so the
// sustained rate is one byte per cycle while bytes average at most one token
// each and the sink is ready. No clearing pass after reset.
module latex_math_tokenizer_unit import lmt_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [7:0] s_tdata,   // ch
  input  logic s_tlast,         // end_of_input
  output logic m_tvalid,
  input  logic m_tready,
  output logic [((4 + 2 * OFFSET_BITS + 7) / 8) * 8 - 1:0] m_tdata, // tok_kind, tok_start, tok_length
  output logic m_tlast          // run_last
);

  localparam int TDATA_W = ((4 + 2 * OFFSET_BITS + 7) / 8) * 8;

  logic                        acc;
  logic                        busy;
  lex_ctl_t                    ctl;
  logic [2:0][OFFSET_BITS-1:0] tok_start;
  logic [2:0][OFFSET_BITS-1:0] tok_length;
  logic [BCNT_W-1:0]           q_count;
  tok_kind_t                   out_kind;
  logic [OFFSET_BITS-1:0]      out_start;
  logic [OFFSET_BITS-1:0]      out_length;

  assign s_tready = (q_count + BCNT_W'(busy)) < BCNT_W'(BUNDLE_DEPTH);
  assign acc      = s_tvalid && s_tready;

  lmt_lexer #(.OFFSET_BITS(OFFSET_BITS)) u_lexer (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .ch         (s_tdata),
    .eoi        (s_tlast),
    .busy       (busy),
    .ctl        (ctl),
    .tok_start  (tok_start),
    .tok_length (tok_length)
  );

  lmt_token_queue #(.OFFSET_BITS(OFFSET_BITS)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .tok_start  (tok_start),
    .tok_length (tok_length),
    .count      (q_count),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (out_kind),
    .out_start  (out_start),
    .out_length (out_length),
    .out_last   (m_tlast)
  );

  assign m_tdata = TDATA_W'({out_length, out_start, out_kind});

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= BCNT_W'(BUNDLE_DEPTH))
    else $error("token group queue count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> q_count < BCNT_W'(BUNDLE_DEPTH))
    else $error("token group pushed into full queue");

  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> ctl.n_tok != 2'd0)
    else $error("empty token group pushed");

  a_accept_lexes: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> busy)
    else $error("accepted byte not lexed");

endmodule
